### rtl/first_fit_block_allocator_assert.svh
// assertion macros used by the allocator back end
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### rtl/ffba_pkg.sv
package ffba_pkg;

  localparam logic [2:0] FUNC_ALLOC   = 3'd0;
  localparam logic [2:0] FUNC_CALLOC  = 3'd1;
  localparam logic [2:0] FUNC_FREE    = 3'd2;
  localparam logic [2:0] FUNC_REALLOC = 3'd3;
  localparam logic [2:0] FUNC_STATS   = 3'd4;

  localparam logic [1:0] CFG_HEAP_BASE     = 2'd0;
  localparam logic [1:0] CFG_HEAP_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_MAX_REQUEST   = 2'd2;

  localparam logic [31:0] HEAP_BASE_RST     = 32'd0;
  localparam logic [31:0] HEAP_CAPACITY_RST = 32'd1048576;
  localparam logic [26:0] MAX_REQUEST_RST   = 27'd100000000;

  typedef struct packed {
    logic [31:0] heap_base;
    logic [31:0] heap_capacity;
    logic [26:0] max_request;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]  func;
    logic        bad;
    logic [26:0] size;
    logic [31:0] user_addr;
  } cmd_t;

  // result item, lowest field last
  typedef struct packed {
    logic [11:0] meta_byte_total;
    logic [31:0] byte_total;
    logic [6:0]  block_total;
    logic [31:0] free_byte_total;
    logic [6:0]  free_block_count;
    logic [26:0] zero_bytes;
    logic [26:0] move_bytes;
    logic [31:0] move_from;
    logic        ok;
    logic [31:0] result_addr;
  } res_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FIND,
    B_FIT,
    B_APPEND,
    B_RELEASE,
    B_DONE
  } back_state_t;

endpackage

### rtl/ffba_queue.sv
module ffba_queue
  import ffba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/ffba_front.sv
module ffba_front
  import ffba_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   in_func,
  input  logic [31:0]  in_req_size,
  input  logic [31:0]  in_elem_count,
  input  logic [31:0]  in_user_addr,
  output logic         push,
  output cmd_t         push_cmd,
  input  logic         q_full
);

  logic        s1_v;
  logic [2:0]  s1_func;
  logic [31:0] s1_req;
  logic [31:0] s1_cnt;
  logic [31:0] s1_uaddr;
  logic        s2_v;
  logic [2:0]  s2_func;
  logic [31:0] s2_req;
  logic [63:0] s2_prod;
  logic [31:0] s2_uaddr;
  logic        s2_load;
  logic        req_bad;
  logic        prod_bad;

  assign push     = s2_v && !q_full;
  assign s2_load  = s1_v && (!s2_v || push);
  assign in_ready = !s1_v || s2_load;

  assign req_bad  = (s2_req == '0) || (s2_req > {5'd0, cfg.max_request});
  assign prod_bad = (s2_prod == '0) || (s2_prod > {37'd0, cfg.max_request});

  always_comb begin
    push_cmd.func      = s2_func;
    push_cmd.user_addr = s2_uaddr;
    if (s2_func == FUNC_CALLOC) begin
      push_cmd.bad  = req_bad || prod_bad;
      push_cmd.size = s2_prod[26:0];
    end else begin
      push_cmd.bad  = req_bad;
      push_cmd.size = s2_req[26:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_v <= 1'b1;
      end else if (s2_load) begin
        s1_v <= 1'b0;
      end
      if (s2_load) begin
        s2_v <= 1'b1;
      end else if (push) begin
        s2_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func  <= in_func;
      s1_req   <= in_req_size;
      s1_cnt   <= in_elem_count;
      s1_uaddr <= in_user_addr;
    end
    if (s2_load) begin
      s2_func  <= s1_func;
      s2_req   <= s1_req;
      s2_prod  <= 64'(s1_req) * 64'(s1_cnt);
      s2_uaddr <= s1_uaddr;
    end
  end

endmodule

### rtl/ffba_back.sv
module ffba_back
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int META_BYTES = 40,
  parameter int ADDR_BITS  = 32
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int RW = ADDR_BITS + 28;

  back_state_t state;
  back_state_t state_next;

  logic [RW-1:0] mem [MAX_BLOCKS];
  logic [RW-1:0] rd_row;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [RW-1:0] wr_row;

  cmd_t          op;
  logic [CW-1:0] scan_i;
  logic          chk_v;
  logic [IW-1:0] chk_i;
  logic          issue;
  logic          old_v;
  logic [IW-1:0] old_i;
  logic [RW-1:0] old_row;

  logic [31:0] r_addr, r_addr_next;
  logic        r_ok, r_ok_next;
  logic [31:0] r_mfrom, r_mfrom_next;
  logic [26:0] r_mbytes, r_mbytes_next;
  logic [26:0] r_zbytes, r_zbytes_next;
  logic        old_v_next;
  logic [IW-1:0] old_i_next;
  logic [RW-1:0] old_row_next;

  logic [CW-1:0] block_count, block_count_next;
  logic [31:0]   heap_top, heap_top_next;
  logic [6:0]    free_count, free_count_next;
  logic [31:0]   free_bytes, free_bytes_next;
  logic [31:0]   all_bytes, all_bytes_next;

  logic [ADDR_BITS-1:0] rd_start;
  logic [26:0]          rd_size;
  logic                 rd_free;
  logic [63:0]          rd_pay64;
  logic [31:0]          rd_pay;
  logic [33:0]          need;
  logic [64:0]          new_start65;
  logic [ADDR_BITS-1:0] new_start;
  logic [63:0]          new_pay64;
  logic                 hit_find;
  logic                 hit_fit;
  logic                 scan_end;
  logic                 out_load;

  assign rd_start = rd_row[RW-1:28];
  assign rd_size  = rd_row[27:1];
  assign rd_free  = rd_row[0];
  assign rd_pay64 = 64'(rd_start + ADDR_BITS'(META_BYTES));
  assign rd_pay   = rd_pay64[31:0];

  assign need        = {2'd0, heap_top} + 34'(META_BYTES) + {7'd0, op.size};
  assign new_start65 = {33'd0, cfg.heap_base} + {33'd0, heap_top};
  assign new_start   = new_start65[ADDR_BITS-1:0];
  assign new_pay64   = 64'(new_start + ADDR_BITS'(META_BYTES));

  assign hit_find = chk_v && (rd_pay == op.user_addr);
  assign hit_fit  = chk_v && rd_free && (rd_size >= op.size);
  assign scan_end = (scan_i >= block_count) && !chk_v;
  assign issue    = ((state == B_FIND) || (state == B_FIT)) && (scan_i < block_count);

  assign pop       = (state == B_IDLE) && !q_empty;
  assign out_load  = (state == B_DONE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.func)
            FUNC_ALLOC, FUNC_CALLOC: state_next = q_cmd.bad ? B_DONE : B_FIT;
            FUNC_FREE: state_next = (q_cmd.user_addr == '0) ? B_DONE : B_FIND;
            FUNC_REALLOC: begin
              if (q_cmd.bad) begin
                state_next = B_DONE;
              end else if (q_cmd.user_addr == '0) begin
                state_next = B_FIT;
              end else begin
                state_next = B_FIND;
              end
            end
            default: state_next = B_DONE;
          endcase
        end
      end
      B_FIND: begin
        if (hit_find) begin
          if (op.func == FUNC_FREE) begin
            state_next = B_DONE;
          end else if (!rd_free && (rd_size >= op.size)) begin
            state_next = B_DONE;
          end else begin
            state_next = B_FIT;
          end
        end else if (scan_end) begin
          state_next = (op.func == FUNC_FREE) ? B_DONE : B_FIT;
        end
      end
      B_FIT: begin
        if (hit_fit) begin
          state_next = old_v ? B_RELEASE : B_DONE;
        end else if (scan_end) begin
          state_next = B_APPEND;
        end
      end
      B_APPEND: begin
        if ((block_count < CW'(MAX_BLOCKS)) && (need <= {2'd0, cfg.heap_capacity})) begin
          state_next = old_v ? B_RELEASE : B_DONE;
        end else begin
          state_next = B_DONE;
        end
      end
      B_RELEASE: state_next = B_DONE;
      B_DONE: begin
        if (out_load) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // datapath and table writes
  always_comb begin
    r_addr_next      = r_addr;
    r_ok_next        = r_ok;
    r_mfrom_next     = r_mfrom;
    r_mbytes_next    = r_mbytes;
    r_zbytes_next    = r_zbytes;
    old_v_next       = old_v;
    old_i_next       = old_i;
    old_row_next     = old_row;
    block_count_next = block_count;
    heap_top_next    = heap_top;
    free_count_next  = free_count;
    free_bytes_next  = free_bytes;
    all_bytes_next   = all_bytes;
    wr_en            = 1'b0;
    wr_idx           = chk_i;
    wr_row           = {rd_row[RW-1:1], 1'b0};
    case (state)
      B_IDLE: begin
        r_addr_next   = '0;
        r_ok_next     = (q_cmd.func == FUNC_STATS);
        r_mfrom_next  = '0;
        r_mbytes_next = '0;
        r_zbytes_next = '0;
        old_v_next    = 1'b0;
      end
      B_FIND: begin
        if (hit_find) begin
          if (op.func == FUNC_FREE) begin
            r_ok_next = 1'b1;
            if (!rd_free) begin
              wr_en           = 1'b1;
              wr_row          = {rd_row[RW-1:1], 1'b1};
              free_count_next = free_count + 7'd1;
              free_bytes_next = free_bytes + {5'd0, rd_size};
            end
          end else if (!rd_free && (rd_size >= op.size)) begin
            r_ok_next   = 1'b1;
            r_addr_next = op.user_addr;
          end else if (!rd_free) begin
            old_v_next   = 1'b1;
            old_i_next   = chk_i;
            old_row_next = rd_row;
          end
        end
      end
      B_FIT: begin
        if (hit_fit) begin
          wr_en           = 1'b1;
          free_count_next = free_count - 7'd1;
          free_bytes_next = free_bytes - {5'd0, rd_size};
          r_ok_next       = 1'b1;
          r_addr_next     = rd_pay;
          if (op.func == FUNC_CALLOC) begin
            r_zbytes_next = op.size;
          end
        end
      end
      B_APPEND: begin
        if ((block_count < CW'(MAX_BLOCKS)) && (need <= {2'd0, cfg.heap_capacity})) begin
          wr_en            = 1'b1;
          wr_idx           = block_count[IW-1:0];
          wr_row           = {new_start, op.size, 1'b0};
          block_count_next = block_count + CW'(1);
          heap_top_next    = need[31:0];
          all_bytes_next   = all_bytes + {5'd0, op.size};
          r_ok_next        = 1'b1;
          r_addr_next      = new_pay64[31:0];
          if (op.func == FUNC_CALLOC) begin
            r_zbytes_next = op.size;
          end
        end
      end
      B_RELEASE: begin
        wr_en           = 1'b1;
        wr_idx          = old_i;
        wr_row          = {old_row[RW-1:1], 1'b1};
        free_count_next = free_count + 7'd1;
        free_bytes_next = free_bytes + {5'd0, old_row[27:1]};
        r_mfrom_next    = op.user_addr;
        r_mbytes_next   = old_row[27:1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_row <= mem[scan_i[IW-1:0]];
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      block_count <= '0;
      heap_top    <= '0;
      free_count  <= '0;
      free_bytes  <= '0;
      all_bytes   <= '0;
      out_valid   <= 1'b0;
      chk_v       <= 1'b0;
      scan_i      <= '0;
      old_v       <= 1'b0;
    end else begin
      state       <= state_next;
      block_count <= block_count_next;
      heap_top    <= heap_top_next;
      free_count  <= free_count_next;
      free_bytes  <= free_bytes_next;
      all_bytes   <= all_bytes_next;
      old_v       <= old_v_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state_next != state) begin
        scan_i <= '0;
        chk_v  <= 1'b0;
      end else if (issue) begin
        scan_i <= scan_i + CW'(1);
        chk_v  <= 1'b1;
      end else begin
        chk_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= q_cmd;
    end
    if (issue) begin
      chk_i <= scan_i[IW-1:0];
    end
    r_addr   <= r_addr_next;
    r_ok     <= r_ok_next;
    r_mfrom  <= r_mfrom_next;
    r_mbytes <= r_mbytes_next;
    r_zbytes <= r_zbytes_next;
    old_i    <= old_i_next;
    old_row  <= old_row_next;
    if (out_load) begin
      out_res.result_addr      <= r_ok ? r_addr : 32'd0;
      out_res.ok               <= r_ok;
      out_res.move_from        <= r_mfrom;
      out_res.move_bytes       <= r_mbytes;
      out_res.zero_bytes       <= r_zbytes;
      out_res.free_block_count <= free_count;
      out_res.free_byte_total  <= free_bytes;
      out_res.block_total      <= 7'(block_count);
      out_res.byte_total       <= all_bytes;
      out_res.meta_byte_total  <= 12'(block_count * META_BYTES);
    end
  end

  `include "first_fit_block_allocator_assert.svh"

  `FFBA_ASSERT_NOW(a_count_bound, 1'b1, block_count <= CW'(MAX_BLOCKS))
  `FFBA_ASSERT_NEXT(a_done_to_idle, out_load, state == B_IDLE && out_valid)
  `FFBA_ASSERT_NOW(a_fail_null, out_valid && !out_res.ok, out_res.result_addr == 32'd0)
  `FFBA_ASSERT_NOW(a_pop_idle, pop, state == B_IDLE && !q_empty)

endmodule

### rtl/first_fit_block_allocator.sv
// channel   direction  fields (tdata from bit 0)
// s_axis    in         func, req_size, elem_count, user_addr
// m_axis    out        result_addr, ok, move_from, move_bytes, zero_bytes, free_block_count,
//                      free_byte_total, block_total, byte_total, meta_byte_total
// cfg       in         cfg_index selects heap_base, heap_capacity, max_request
//
// an item passes the front register and multiply stages, then waits in a 2-entry queue
// the back walks the block table one entry a cycle from a single memory read port
// statistics-only and rejected items skip the table walk in the back
// rst is synchronous; the table needs no clearing, block count starts at zero
// the front keeps accepting while the back searches, until the queue and both front stages fill
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64,
  parameter int META_BYTES = 40,
  parameter int ADDR_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // func, req_size, elem_count, user_addr
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [215:0] m_axis_tdata,  // result_addr, ok, move_from, move_bytes, zero_bytes,
                                      // free_block_count, free_byte_total, block_total,
                                      // byte_total, meta_byte_total
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t pop_cmd;
  logic q_empty;
  res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base     <= HEAP_BASE_RST;
      cfg.heap_capacity <= HEAP_CAPACITY_RST;
      cfg.max_request   <= MAX_REQUEST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_BASE:     cfg.heap_base     <= cfg_data;
        CFG_HEAP_CAPACITY: cfg.heap_capacity <= cfg_data;
        CFG_MAX_REQUEST:   cfg.max_request   <= cfg_data[26:0];
        default: begin
        end
      endcase
    end
  end

  ffba_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_func       (s_axis_tdata[2:0]),
    .in_req_size   (s_axis_tdata[34:3]),
    .in_elem_count (s_axis_tdata[66:35]),
    .in_user_addr  (s_axis_tdata[98:67]),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  ffba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  ffba_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .META_BYTES (META_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res};

endmodule
